### hdl/hrhs_pkg.sv
// ----------------------------------------------------------------------------
// hrhs_pkg
// Shared types and constants for the HTTP response header scanner.
// ----------------------------------------------------------------------------
package hrhs_pkg;

  localparam int HEADER_COUNT_BITS = 16;
  localparam int BODY_COUNT_BITS   = 32;

  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_SP      = 8'h20;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [15:0] STATUS_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_PROTO  = 4'd0,
    ST_WHITE  = 4'd1,
    ST_STATUS = 4'd2,
    ST_TEXT   = 4'd3,
    ST_LF     = 4'd4,
    ST_CR     = 4'd5,
    ST_CRLF   = 4'd6,
    ST_CRLFCR = 4'd7,
    ST_BODY   = 4'd8
  } scan_state_t;

  typedef logic [HEADER_COUNT_BITS-1:0] header_count_t;
  typedef logic [BODY_COUNT_BITS-1:0]   body_count_t;

endpackage

### hdl/http_response_header_scanner.sv
// ----------------------------------------------------------------------------
// http_response_header_scanner
// Byte-wide scanner that picks the status code out of an HTTP response and
// finds the blank line that ends its header block.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                   Payload
//  -------  --------------------------  --------------------------------------
//  input    data_valid / data_ready     data_byte, start_of_response
//  output   result_valid / result_ready headers_end, in_body, status_code,
//                                       header_length, body_bytes
//
// One byte is taken in every cycle unless the output stalls; its result
// appears in the output register on the following cycle. The scan state and
// counters update in the same cycle as the transfer, so throughput is set
// only by the output register. While a result is held by a stalled output,
// data_ready is low unless that result is taken in the same cycle. Reset
// clears the scan state, counters and the output valid flag.
//
module http_response_header_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_response,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        headers_end,
  output logic        in_body,
  output logic [15:0] status_code,
  output logic [15:0] header_length,
  output logic [31:0] body_bytes
);
  import hrhs_pkg::*;

  scan_state_t   scan_state, scan_state_next;
  logic [15:0]   status_acc, status_acc_next;
  header_count_t header_count, header_count_next;
  body_count_t   body_count, body_count_next;

  scan_state_t   cur_state;
  logic [15:0]   cur_status;
  header_count_t cur_header;
  body_count_t   cur_body;

  logic          accept;
  logic          is_digit;
  logic [3:0]    digit;
  logic [19:0]   status_pushed;
  logic          ended;
  logic          body;

  assign data_ready = !result_valid || result_ready;
  assign accept     = data_valid && data_ready;

  // A start flag makes the byte see freshly cleared state.
  assign cur_state  = start_of_response ? ST_PROTO : scan_state;
  assign cur_status = start_of_response ? 16'd0 : status_acc;
  assign cur_header = start_of_response ? '0 : header_count;
  assign cur_body   = start_of_response ? '0 : body_count;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit    = 4'(data_byte - CH_ZERO);

  // Times ten as two shifted copies, then the new digit.
  assign status_pushed = {1'b0, cur_status, 3'b000} + {3'b000, cur_status, 1'b0}
                       + {16'd0, digit};

  always_comb begin
    scan_state_next = cur_state;
    ended           = 1'b0;
    unique case (cur_state)
      ST_PROTO: begin
        if (data_byte == CH_SP || data_byte == CH_TAB) scan_state_next = ST_WHITE;
        else if (data_byte == CH_LF) scan_state_next = ST_LF;
        else if (data_byte == CH_CR) scan_state_next = ST_CR;
      end
      ST_WHITE, ST_STATUS: begin
        if (is_digit) scan_state_next = ST_STATUS;
        else if (data_byte == CH_LF) scan_state_next = ST_LF;
        else if (data_byte == CH_CR) scan_state_next = ST_CR;
        else scan_state_next = ST_TEXT;
      end
      ST_TEXT: begin
        if (data_byte == CH_LF) scan_state_next = ST_LF;
        else if (data_byte == CH_CR) scan_state_next = ST_CR;
      end
      ST_LF: begin
        if (data_byte == CH_LF) ended = 1'b1;
        else if (data_byte == CH_CR) scan_state_next = ST_CR;
        else scan_state_next = ST_TEXT;
      end
      ST_CR: begin
        if (data_byte == CH_LF) scan_state_next = ST_CRLF;
        else if (data_byte == CH_CR) ended = 1'b1;
        else scan_state_next = ST_TEXT;
      end
      ST_CRLF: begin
        if (data_byte == CH_LF) ended = 1'b1;
        else if (data_byte == CH_CR) scan_state_next = ST_CRLFCR;
        else scan_state_next = ST_TEXT;
      end
      ST_CRLFCR: begin
        if (data_byte == CH_LF || data_byte == CH_CR) ended = 1'b1;
        else scan_state_next = ST_TEXT;
      end
      ST_BODY: begin
        scan_state_next = ST_BODY;
      end
      default: begin
        scan_state_next = ST_TEXT;
      end
    endcase
    if (ended) scan_state_next = ST_BODY;
  end

  always_comb begin
    body              = (cur_state == ST_BODY);
    status_acc_next   = cur_status;
    header_count_next = cur_header;
    body_count_next   = cur_body;
    if (body) begin
      if (cur_body != '1) body_count_next = cur_body + 1'b1;
    end else begin
      if (cur_header != '1) header_count_next = cur_header + 1'b1;
      if (is_digit && cur_state == ST_WHITE) begin
        status_acc_next = {12'd0, digit};
      end else if (is_digit && cur_state == ST_STATUS) begin
        status_acc_next = (status_pushed[19:16] != 4'd0) ? STATUS_MAX
                                                         : status_pushed[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state   <= ST_PROTO;
      status_acc   <= 16'd0;
      header_count <= '0;
      body_count   <= '0;
    end else if (accept) begin
      scan_state   <= scan_state_next;
      status_acc   <= status_acc_next;
      header_count <= header_count_next;
      body_count   <= body_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      headers_end   <= ended;
      in_body       <= body;
      status_code   <= status_acc_next;
      header_length <= 16'(header_count_next);
      body_bytes    <= 32'(body_count_next);
    end
  end

`ifndef SYNTHESIS
  // The byte that ends the headers is never itself a body byte.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(headers_end && in_body))
    else $error("headers_end and in_body both set");

  // Once in the body, every further byte of the same response is body.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !start_of_response && scan_state == ST_BODY) |=>
      (result_valid && in_body && !headers_end))
    else $error("body byte not reported as body");

  // A transfer in always leaves a result waiting.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted byte produced no result");
`endif

endmodule
